// ----- hw/rtl/mltc_pkg.sv -----
// Shared types and constants for the mutex lock trace checker.
`timescale 1ns / 1ps
`default_nettype none
package mltc_pkg;

  localparam int unsigned ID_W      = 32;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned OPS_W     = 32;
  localparam int unsigned MAX_SLOTS = 16;
  localparam int unsigned ST_W      = 3;

  typedef enum logic [1:0] {
    CMD_LOCK   = 2'd0,
    CMD_UNLOCK = 2'd1,
    CMD_OTHER  = 2'd2,
    CMD_END    = 2'd3
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    STAT_OK          = 3'd0,
    STAT_UNLOCK_FREE = 3'd1,
    STAT_LOCK_HELD   = 3'd2,
    STAT_TABLE_FULL  = 3'd3,
    STAT_IGNORED     = 3'd4,
    STAT_LEFT_LOCKED = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_THREAD,
    ST_MUTEX,
    ST_EMIT,
    ST_REPORT
  } chk_state_t;

  typedef enum logic [1:0] {
    LK_IDLE,
    LK_SCAN,
    LK_MISS
  } lkp_state_t;

  typedef struct packed {
    logic            start;
    logic [ID_W-1:0] id;
  } lkp_req_t;

  typedef struct packed {
    logic             done;
    logic             full;
    logic [IDX_W-1:0] index;
  } lkp_rsp_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mltc_if.sv -----
// Valid/ready channel interfaces for trace events and check results.
`timescale 1ns / 1ps
`default_nettype none
interface mltc_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                cmd;
  logic [mltc_pkg::ID_W-1:0] thread_id;
  logic [mltc_pkg::ID_W-1:0] mutex_id;

  modport source (output valid, cmd, thread_id, mutex_id, input ready);
  modport sink   (input valid, cmd, thread_id, mutex_id, output ready);
endinterface

interface mltc_out_if;
  logic                       valid;
  logic                       ready;
  logic [mltc_pkg::IDX_W-1:0] thread_index;
  logic [mltc_pkg::IDX_W-1:0] mutex_index;
  logic [mltc_pkg::ST_W-1:0]  status;
  logic [mltc_pkg::OPS_W-1:0] op_count;
  logic                       last;

  modport source (output valid, thread_index, mutex_index, status, op_count, last,
                  input ready);
  modport sink   (input valid, thread_index, mutex_index, status, op_count, last,
                  output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/mutex_lock_trace_checker.sv -----
// Top level: event sequencer, held bits, counters and result register.
// Lock/unlock/other: the thread id and then, unless its table is full, the mutex id are
//   found or appended by serial scans before the result is loaded; a halted event skips them.
// End report: one result per mutex index left locked, then a summary marked last.
// One event at a time; the next event is taken once the last result is loaded.
// Synchronous active-low reset clears tables' fill counts, held bits, count, halt.
`timescale 1ns / 1ps
`default_nettype none
module mutex_lock_trace_checker #(
  parameter int unsigned THREAD_SLOTS = 16,
  parameter int unsigned MUTEX_SLOTS  = 16
) (
  input wire   clk,
  input wire   rst_n,
  mltc_in_if.sink    in_ch,
  mltc_out_if.source out_ch
);
  import mltc_pkg::*;

  chk_state_t       state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [ID_W-1:0]  mid_r;
  logic [IDX_W-1:0] ti_r, ti_nxt;
  logic [IDX_W-1:0] res_ti_r, res_ti_nxt;
  logic [IDX_W-1:0] res_mi_r, res_mi_nxt;
  status_t          res_st_r, res_st_nxt;
  logic [MAX_SLOTS-1:0] held_r, held_nxt;
  logic [OPS_W-1:0] ops_r, ops_nxt;
  logic             halted_r, halted_nxt;
  logic [CNT_W-1:0] rep_idx_r, rep_idx_nxt;

  logic             out_valid_r;
  logic [IDX_W-1:0] out_ti_r, out_ti_nxt;
  logic [IDX_W-1:0] out_mi_r, out_mi_nxt;
  status_t          out_st_r, out_st_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_load;
  logic             out_free;

  logic             in_fire;
  logic             mid_load;
  lkp_req_t         thr_req, mtx_req;
  lkp_rsp_t         thr_rsp, mtx_rsp;
  logic             held_hit;
  logic             rep_done;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign held_hit = held_r[mtx_rsp.index];
  assign rep_done = (rep_idx_r == CNT_W'(MAX_SLOTS));

  mltc_id_lookup #(.SLOTS(THREAD_SLOTS)) u_thr_lookup (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (thr_req),
    .rsp   (thr_rsp)
  );

  mltc_id_lookup #(.SLOTS(MUTEX_SLOTS)) u_mtx_lookup (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mtx_req),
    .rsp   (mtx_rsp)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (cmd_t'(in_ch.cmd) == CMD_END) begin
            state_nxt = ST_REPORT;
          end else if (halted_r) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_THREAD;
          end
        end
      end
      ST_THREAD: begin
        if (thr_rsp.done) begin
          state_nxt = thr_rsp.full ? ST_EMIT : ST_MUTEX;
        end
      end
      ST_MUTEX: begin
        if (mtx_rsp.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_REPORT: begin
        if (rep_done && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    in_ch.ready  = 1'b0;
    thr_req      = '0;
    mtx_req      = '0;
    mid_load     = 1'b0;
    cmd_nxt      = cmd_r;
    ti_nxt       = ti_r;
    res_ti_nxt   = res_ti_r;
    res_mi_nxt   = res_mi_r;
    res_st_nxt   = res_st_r;
    held_nxt     = held_r;
    ops_nxt      = ops_r;
    halted_nxt   = halted_r;
    rep_idx_nxt  = rep_idx_r;
    out_load     = 1'b0;
    out_ti_nxt   = '0;
    out_mi_nxt   = '0;
    out_st_nxt   = STAT_OK;
    out_last_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        rep_idx_nxt = '0;
        if (in_fire) begin
          cmd_nxt    = cmd_t'(in_ch.cmd);
          mid_load   = 1'b1;
          res_ti_nxt = '0;
          res_mi_nxt = '0;
          res_st_nxt = STAT_IGNORED;
          if (cmd_t'(in_ch.cmd) != CMD_END && !halted_r) begin
            thr_req.start = 1'b1;
            thr_req.id    = in_ch.thread_id;
          end
        end
      end
      ST_THREAD: begin
        if (thr_rsp.done) begin
          if (thr_rsp.full) begin
            halted_nxt = 1'b1;
            res_st_nxt = STAT_TABLE_FULL;
          end else begin
            ti_nxt        = thr_rsp.index;
            mtx_req.start = 1'b1;
            mtx_req.id    = mid_r;
          end
        end
      end
      ST_MUTEX: begin
        if (mtx_rsp.done) begin
          res_ti_nxt = ti_r;
          if (mtx_rsp.full) begin
            halted_nxt = 1'b1;
            res_st_nxt = STAT_TABLE_FULL;
          end else begin
            res_mi_nxt = mtx_rsp.index;
            res_st_nxt = STAT_OK;
            ops_nxt    = ops_r + OPS_W'(1);
            case (cmd_r)
              CMD_UNLOCK: begin
                if (!held_hit) begin
                  halted_nxt = 1'b1;
                  res_st_nxt = STAT_UNLOCK_FREE;
                end else begin
                  held_nxt[mtx_rsp.index] = 1'b0;
                end
              end
              CMD_LOCK: begin
                if (held_hit) begin
                  halted_nxt = 1'b1;
                  res_st_nxt = STAT_LOCK_HELD;
                end else begin
                  held_nxt[mtx_rsp.index] = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_ti_nxt   = res_ti_r;
          out_mi_nxt   = res_mi_r;
          out_st_nxt   = res_st_r;
          out_last_nxt = 1'b1;
        end
      end
      ST_REPORT: begin
        if (rep_done) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_last_nxt = 1'b1;
          end
        end else if (held_r[rep_idx_r[IDX_W-1:0]]) begin
          if (out_free) begin
            out_load    = 1'b1;
            out_mi_nxt  = rep_idx_r[IDX_W-1:0];
            out_st_nxt  = STAT_LEFT_LOCKED;
            rep_idx_nxt = rep_idx_r + CNT_W'(1);
          end
        end else begin
          rep_idx_nxt = rep_idx_r + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (mid_load) begin
      mid_r <= in_ch.mutex_id;
    end
    cmd_r     <= cmd_nxt;
    ti_r      <= ti_nxt;
    res_ti_r  <= res_ti_nxt;
    res_mi_r  <= res_mi_nxt;
    res_st_r  <= res_st_nxt;
    rep_idx_r <= rep_idx_nxt;
    if (out_load) begin
      out_ti_r   <= out_ti_nxt;
      out_mi_r   <= out_mi_nxt;
      out_st_r   <= out_st_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= '0;
      ops_r       <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      held_r   <= held_nxt;
      ops_r    <= ops_nxt;
      halted_r <= halted_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Drive the result channel; the count is read when the transaction is loaded
  logic [OPS_W-1:0] out_ops_r;
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ops_r <= ops_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.thread_index = out_ti_r;
  assign out_ch.mutex_index  = out_mi_r;
  assign out_ch.status       = out_st_r;
  assign out_ch.op_count     = out_ops_r;
  assign out_ch.last         = out_last_r;

`ifndef SYNTHESIS
  a_held_only_on_check: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r == ST_MUTEX && mtx_rsp.done) |=> $stable(held_r))
    else $error("held bits changed outside a mutex check");

  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt cleared without reset");

  a_ops_step: assert property (@(posedge clk) disable iff (!rst_n)
    (ops_r != $past(ops_r)) |-> (ops_r == $past(ops_r) + OPS_W'(1)))
    else $error("operation count moved by more than one");

  a_thr_done_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
    thr_rsp.done |-> (state_r == ST_THREAD))
    else $error("thread lookup finished outside the thread phase");

  a_mtx_done_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mtx_rsp.done |-> (state_r == ST_MUTEX))
    else $error("mutex lookup finished outside the mutex phase");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/mltc_id_lookup.sv -----
// Id table in a synchronous memory with serial find-or-append lookup.
`timescale 1ns / 1ps
`default_nettype none
module mltc_id_lookup #(
  parameter int unsigned SLOTS = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  input  mltc_pkg::lkp_req_t req,
  output mltc_pkg::lkp_rsp_t rsp
);
  import mltc_pkg::*;

  localparam logic [CNT_W-1:0] LIMIT =
    (SLOTS > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : CNT_W'(SLOTS);

  logic [ID_W-1:0]  mem [MAX_SLOTS];
  logic [ID_W-1:0]  rd_data_r;
  logic [IDX_W-1:0] rd_addr;

  lkp_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [ID_W-1:0]  id_r;
  logic             hit;
  logic             scan_end;
  logic             is_full;
  logic             wr_en;

  assign hit      = (rd_data_r == id_r);
  assign scan_end = (({1'b0, cmp_idx_r} + CNT_W'(1)) == used_r);
  assign is_full  = (used_r >= LIMIT);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      LK_IDLE: begin
        if (req.start) begin
          state_nxt = (used_r == '0) ? LK_MISS : LK_SCAN;
        end
      end
      LK_SCAN: begin
        if (hit) begin
          state_nxt = LK_IDLE;
        end else if (scan_end) begin
          state_nxt = LK_MISS;
        end
      end
      LK_MISS: state_nxt = LK_IDLE;
      default: state_nxt = LK_IDLE;
    endcase
  end

  // Outputs and datapath controls
  always_comb begin
    rsp         = '0;
    wr_en       = 1'b0;
    used_nxt    = used_r;
    cmp_idx_nxt = cmp_idx_r;
    rd_addr     = '0;
    unique case (state_r)
      LK_IDLE: begin
        cmp_idx_nxt = '0;
      end
      LK_SCAN: begin
        rd_addr     = cmp_idx_r + IDX_W'(1);
        cmp_idx_nxt = cmp_idx_r + IDX_W'(1);
        if (hit) begin
          rsp.done  = 1'b1;
          rsp.index = cmp_idx_r;
        end
      end
      LK_MISS: begin
        rsp.done = 1'b1;
        if (is_full) begin
          rsp.full = 1'b1;
        end else begin
          rsp.index = used_r[IDX_W-1:0];
          wr_en     = 1'b1;
          used_nxt  = used_r + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[used_r[IDX_W-1:0]] <= id_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Hold the searched id and the scan position
  always_ff @(posedge clk) begin
    if (state_r == LK_IDLE && req.start) begin
      id_r <= req.id;
    end
    cmp_idx_r <= cmp_idx_nxt;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LK_IDLE;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
    end
  end

endmodule
`default_nettype wire
